// ----- rtl/xsbd_pkg.sv -----
// Shared types, codes and byte constants for the x86 subset byte decoder.
`default_nettype none

package xsbd_pkg;

	// Opcode and prefix bytes recognised by the decoder.
	localparam logic [7:0] BYTE_F3      = 8'hF3;
	localparam logic [7:0] BYTE_0F      = 8'h0F;
	localparam logic [7:0] BYTE_1E      = 8'h1E;
	localparam logic [7:0] BYTE_FA      = 8'hFA;
	localparam logic [7:0] BYTE_XOR     = 8'h31;
	localparam logic [7:0] BYTE_MOV     = 8'h89;
	localparam logic [7:0] BYTE_REGGRP  = 8'h58;
	localparam logic [7:0] MASK_REGGRP  = 8'b1111_1000;
	localparam logic [7:0] MASK_REX     = 8'b1111_0000;
	localparam logic [7:0] BYTE_REX     = 8'b0100_0000;
	localparam logic [2:0] RM_SIB       = 3'b100;
	localparam logic [1:0] MOD_REGISTER = 2'b11;

	// Decoder phase; unused codes behave as the prefix phase.
	typedef enum logic [2:0] {
		PH_PREFIX   = 3'd0,
		PH_OPCODE   = 3'd1,
		PH_AFTER_0F = 3'd2,
		PH_AFTER_1E = 3'd3,
		PH_MODRM    = 3'd4
	} phase_t;

	// Operation waiting for its ModRM byte.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_XOR  = 2'd1,
		OP_MOV  = 2'd2
	} pending_op_t;

	// Result classification.
	typedef enum logic [2:0] {
		K_INVALID = 3'd0,
		K_ENDBR   = 3'd1,
		K_XOR     = 3'd2,
		K_MOV     = 3'd3,
		K_REGGRP  = 3'd4,
		K_SIB     = 3'd5
	} kind_t;

	// Decoder state carried between bytes.
	typedef struct packed {
		phase_t      phase;
		logic        rex_seen;
		logic [3:0]  rex_bits;
		pending_op_t pending_op;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:      PH_PREFIX,
		rex_seen:   1'b0,
		rex_bits:   4'd0,
		pending_op: OP_NONE
	};

	// Request on the input channel.
	typedef struct packed {
		logic [7:0] instr_byte;
	} in_item_t;

	// Request on the result channel.
	typedef struct packed {
		kind_t      kind;
		logic       rex_present;
		logic       rex_w;
		logic       rex_x;
		logic       rex_r;
		logic       rex_b;
		logic [1:0] mod_field;
		logic [3:0] reg_field;
		logic [3:0] rm_field;
		logic [2:0] opcode_reg;
		logic [7:0] modrm_raw;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/xsbd_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per request.
`default_nettype none

interface xsbd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/x86_subset_byte_decoder_top.sv -----
// Top level of the x86 subset byte decoder: input stage, decode step and result register.
//
//   channel  direction  payload                     handshake
//   instr    in         instr_byte (8 bits)         valid / ready
//   result   out        kind, rex_*, ModRM fields   valid / ready
//
// One instruction byte is accepted per cycle while the result side keeps up.
// A byte is registered in the input stage, then the decode step updates the
// state and, when an instruction ends, loads the result register.
// The input stage drains even while a result waits, so long as its byte ends no instruction.
// Reset (arst_n low) returns the decoder to the prefix phase with no REX taken.
`default_nettype none

module x86_subset_byte_decoder_top (
	input  var logic       clk,
	input  var logic       arst_n,
	xsbd_stream_if.sink    instr,
	xsbd_stream_if.source  result
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       s1_go;
	logic       in_fire;

	// Decoder state and step outputs.
	xsbd_pkg::state_t    state_q;
	xsbd_pkg::state_t    step_nxt;
	logic                step_emit;
	xsbd_pkg::out_item_t step_res;

	// Result register.
	logic                out_valid_q;
	xsbd_pkg::out_item_t out_data_q;
	logic                out_free;

	assign out_free    = !out_valid_q || result.ready;
	assign s1_go       = valid_s1 && (!step_emit || out_free);
	assign instr.ready = !valid_s1 || s1_go;
	assign in_fire     = instr.valid && instr.ready;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	// Input stage byte.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= instr.data.instr_byte;
		end
	end

	xsbd_step u_step (
		.cur        (state_q),
		.instr_byte (byte_s1),
		.nxt        (step_nxt),
		.emit       (step_emit),
		.res        (step_res)
	);

	// Decoder state advances once per byte leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xsbd_pkg::STATE_RESET;
		end else if (s1_go) begin
			state_q <= step_nxt;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && step_emit;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (s1_go && step_emit) begin
			out_data_q <= step_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// Finishing an instruction always leaves the decoder in its start state.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && step_emit) |=> (state_q.phase == xsbd_pkg::PH_PREFIX && !state_q.rex_seen &&
		                          state_q.rex_bits == 4'd0))
		else $error("decoder state not cleared after a result");

	// Waiting for ModRM implies a known pending operation.
	a_modrm_has_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == xsbd_pkg::PH_MODRM) |->
		(state_q.pending_op == xsbd_pkg::OP_XOR || state_q.pending_op == xsbd_pkg::OP_MOV))
		else $error("ModRM phase without a pending operation");

	// Results without a ModRM byte carry zero ModRM fields.
	a_no_modrm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q.kind == xsbd_pkg::K_INVALID ||
		                 out_data_q.kind == xsbd_pkg::K_ENDBR ||
		                 out_data_q.kind == xsbd_pkg::K_REGGRP)) |->
		(out_data_q.modrm_raw == 8'd0 && out_data_q.mod_field == 2'd0 &&
		 out_data_q.reg_field == 4'd0 && out_data_q.rm_field == 4'd0))
		else $error("ModRM fields set on a result without ModRM");

	// REX bits are only reported when a REX byte was taken.
	a_rex_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.rex_present) |->
		(!out_data_q.rex_w && !out_data_q.rex_x && !out_data_q.rex_r && !out_data_q.rex_b))
		else $error("REX bits set without a REX byte");

	// The input stage only holds a byte back while a result is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |-> (step_emit && out_valid_q && !result.ready))
		else $error("input stage stalled without a blocked result");

endmodule

`default_nettype wire

// ----- rtl/xsbd_step.sv -----
// Combinational decode of one instruction byte against the current decoder state.
`default_nettype none

module xsbd_step (
	input  var xsbd_pkg::state_t    cur,
	input  var logic [7:0]          instr_byte,
	output var xsbd_pkg::state_t    nxt,
	output var logic                emit,
	output var xsbd_pkg::out_item_t res
);

	// Opcode decode, shared by the prefix and after-F3 phases.
	logic                  op_finish;
	xsbd_pkg::kind_t       op_kind;
	xsbd_pkg::phase_t      op_phase;
	xsbd_pkg::pending_op_t op_pending;

	always_comb begin
		op_finish  = 1'b0;
		op_kind    = xsbd_pkg::K_INVALID;
		op_phase   = cur.phase;
		op_pending = cur.pending_op;
		if (instr_byte == xsbd_pkg::BYTE_0F) begin
			op_phase = xsbd_pkg::PH_AFTER_0F;
		end else if (instr_byte == xsbd_pkg::BYTE_XOR) begin
			op_phase   = xsbd_pkg::PH_MODRM;
			op_pending = xsbd_pkg::OP_XOR;
		end else if (instr_byte == xsbd_pkg::BYTE_MOV) begin
			op_phase   = xsbd_pkg::PH_MODRM;
			op_pending = xsbd_pkg::OP_MOV;
		end else if ((instr_byte & xsbd_pkg::MASK_REGGRP) == xsbd_pkg::BYTE_REGGRP) begin
			op_finish = 1'b1;
			op_kind   = xsbd_pkg::K_REGGRP;
		end else begin
			op_finish = 1'b1;
		end
	end

	// Phase step: either advance the state or finish the instruction.
	logic            fin;
	logic            has_modrm;
	logic            use_opreg;
	xsbd_pkg::kind_t kind;

	always_comb begin
		nxt       = cur;
		fin       = 1'b0;
		has_modrm = 1'b0;
		use_opreg = 1'b0;
		kind      = xsbd_pkg::K_INVALID;
		case (cur.phase)
			xsbd_pkg::PH_OPCODE: begin
				fin            = op_finish;
				kind           = op_kind;
				use_opreg      = (op_kind == xsbd_pkg::K_REGGRP);
				nxt.phase      = op_phase;
				nxt.pending_op = op_pending;
			end
			xsbd_pkg::PH_AFTER_0F: begin
				if (instr_byte == xsbd_pkg::BYTE_1E) begin
					nxt.phase = xsbd_pkg::PH_AFTER_1E;
				end else begin
					fin = 1'b1;
				end
			end
			xsbd_pkg::PH_AFTER_1E: begin
				fin  = 1'b1;
				kind = (instr_byte == xsbd_pkg::BYTE_FA) ? xsbd_pkg::K_ENDBR
				                                         : xsbd_pkg::K_INVALID;
			end
			xsbd_pkg::PH_MODRM: begin
				fin       = 1'b1;
				has_modrm = 1'b1;
				if (instr_byte[7:6] != xsbd_pkg::MOD_REGISTER &&
				    instr_byte[2:0] == xsbd_pkg::RM_SIB) begin
					kind = xsbd_pkg::K_SIB;
				end else if (cur.pending_op == xsbd_pkg::OP_XOR) begin
					kind = xsbd_pkg::K_XOR;
				end else begin
					kind = xsbd_pkg::K_MOV;
				end
			end
			default: begin
				// Prefix phase: F3, a first REX byte, or straight to the opcode.
				if (instr_byte == xsbd_pkg::BYTE_F3) begin
					nxt.phase = xsbd_pkg::PH_OPCODE;
				end else if ((instr_byte & xsbd_pkg::MASK_REX) == xsbd_pkg::BYTE_REX &&
				             !cur.rex_seen) begin
					nxt.phase    = xsbd_pkg::PH_PREFIX;
					nxt.rex_seen = 1'b1;
					nxt.rex_bits = instr_byte[3:0];
				end else begin
					fin            = op_finish;
					kind           = op_kind;
					use_opreg      = (op_kind == xsbd_pkg::K_REGGRP);
					nxt.phase      = op_phase;
					nxt.pending_op = op_pending;
				end
			end
		endcase
		if (fin) begin
			nxt = xsbd_pkg::STATE_RESET;
		end
	end

	// Result fields; ModRM fields stay zero unless a ModRM byte was taken.
	always_comb begin
		emit            = fin;
		res             = '0;
		res.kind        = kind;
		res.rex_present = cur.rex_seen;
		res.rex_w       = cur.rex_bits[3];
		res.rex_r       = cur.rex_bits[2];
		res.rex_x       = cur.rex_bits[1];
		res.rex_b       = cur.rex_bits[0];
		if (has_modrm) begin
			res.mod_field = instr_byte[7:6];
			res.reg_field = {cur.rex_bits[2], instr_byte[5:3]};
			res.rm_field  = {cur.rex_bits[0], instr_byte[2:0]};
			res.modrm_raw = instr_byte;
		end
		if (use_opreg) begin
			res.opcode_reg = instr_byte[2:0];
		end
	end

endmodule

`default_nettype wire
